FILE: sv/spherical_shell_region_eval_macros.svh
// Assertion macros for the spherical shell region evaluator.
`ifndef SPHERICAL_SHELL_REGION_EVAL_MACROS_SVH
`define SPHERICAL_SHELL_REGION_EVAL_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define SSRE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
// Clocked check that also holds during reset.
`define SSRE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define SSRE_ASSERT(lbl, clk, rstn, prop)
`define SSRE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: sv/ssre_pkg.sv
// ----------------------------------------------------------------------------
// ssre_pkg
// Codes and fixed constants of the spherical shell region evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssre_pkg;

    // Gradient format is Q2.30 in a 32-bit word.
    localparam int GRAD_FRAC = 30;
    localparam int GRAD_W    = 32;
    localparam int QUOT_W    = GRAD_FRAC + 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 3'd4;

    localparam logic [1:0] REGION_INNER = 2'd0;
    localparam logic [1:0] REGION_BLEND = 2'd1;
    localparam logic [1:0] REGION_OUTER = 2'd2;

endpackage

`default_nettype wire

FILE: sv/spherical_shell_region_eval.sv
// ----------------------------------------------------------------------------
// spherical_shell_region_eval
// Distance, unit gradient and shell region of a point against a sphere center.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          item
//  s_*       in         s_tvalid s_tready s_tdata        one query point
//  m_*       out        m_tvalid m_tready m_tdata m_tuser one result
//  cfg_*     in         cfg_we cfg_index cfg_wdata       register write
//
// One item per cycle while the output is not stalled. The stages are offset,
// squares, sum and region, then the square root pipeline, the stages of the
// three dividers and one output stage.
// Every stage carries a valid bit and holds only when the next stage is full
// and stalled, so empty stages keep accepting items while a result waits.
// Reset clears the valid bits and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
`include "spherical_shell_region_eval_macros.svh"

module spherical_shell_region_eval #(
    parameter int COORD_WIDTH = 32,
    localparam int IN_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((COORD_WIDTH + 2 + 3 * ssre_pkg::GRAD_W + 7) / 8) * 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // point_x, point_y, point_z from the lowest bit up
    input  wire logic [IN_W-1:0]                 s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // distance, grad_x, grad_y, grad_z from the lowest bit up
    output logic [OUT_W-1:0]                     m_tdata,
    // region, degenerate from the lowest bit up
    output logic [2:0]                           m_tuser,
    input  wire logic                            cfg_we,
    input  wire logic [ssre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COORD_WIDTH-1:0]          cfg_wdata
);

    localparam int CW = COORD_WIDTH;
    localparam int RW = CW + 1;          // offset magnitude and root width
    localparam int SW = 2 * CW + 2;      // squared distance width
    localparam int GQ = ssre_pkg::QUOT_W;
    localparam int GW = ssre_pkg::GRAD_W;
    localparam int NS = 4 + RW + GQ + 1; // pipeline stages

    // Configuration registers.
    logic [CW-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic [CW-2:0] inner_radius_reg, outer_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            center_z_reg     <= '0;
            inner_radius_reg <= '0;
            outer_radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssre_pkg::CFG_CENTER_X:     center_x_reg     <= cfg_wdata;
                ssre_pkg::CFG_CENTER_Y:     center_y_reg     <= cfg_wdata;
                ssre_pkg::CFG_CENTER_Z:     center_z_reg     <= cfg_wdata;
                ssre_pkg::CFG_INNER_RADIUS: inner_radius_reg <= cfg_wdata[CW-2:0];
                ssre_pkg::CFG_OUTER_RADIUS: outer_radius_reg <= cfg_wdata[CW-2:0];
                default: ;
            endcase
        end
    end

    // Valid bits and the stage enables; a stage loads when it is empty or
    // its content moves on.
    logic [NS-1:0] valid_reg;
    logic [NS:0]   stage_en;

    assign stage_en[NS] = m_tready;
    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_en
            assign stage_en[gi] = !valid_reg[gi] || stage_en[gi+1];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = stage_en[0];

    // Stage 1: offsets from the center as sign and magnitude.
    logic [CW-1:0] pt [3];
    logic [CW-1:0] ct [3];
    logic [RW-1:0] off_next [3];
    assign pt[0] = s_tdata[CW-1:0];
    assign pt[1] = s_tdata[2*CW-1:CW];
    assign pt[2] = s_tdata[3*CW-1:2*CW];
    assign ct[0] = center_x_reg;
    assign ct[1] = center_y_reg;
    assign ct[2] = center_z_reg;

    logic [RW-1:0] s1_mag_reg [3];
    logic [2:0]    s1_sign_reg;
    logic          s1_degen_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            off_next[l] = {pt[l][CW-1], pt[l]} - {ct[l][CW-1], ct[l]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            for (int l = 0; l < 3; l++)
            begin
                s1_sign_reg[l] <= off_next[l][RW-1];
                s1_mag_reg[l]  <= off_next[l][RW-1] ? (RW'(0) - off_next[l]) : off_next[l];
            end
            s1_degen_reg <= (off_next[0] == '0) && (off_next[1] == '0) && (off_next[2] == '0);
        end
    end

    // Stage 2: squares of the offsets and of the radii.
    logic [SW-1:0]   s2_sq_reg [3];
    logic [SW-3:0]   s2_ri2_reg, s2_ro2_reg;
    logic [RW-1:0]   s2_mag_reg [3];
    logic [2:0]      s2_sign_reg;
    logic            s2_degen_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            for (int l = 0; l < 3; l++)
            begin
                s2_sq_reg[l]  <= SW'(s1_mag_reg[l]) * SW'(s1_mag_reg[l]);
                s2_mag_reg[l] <= s1_mag_reg[l];
            end
            s2_ri2_reg   <= (SW-2)'(inner_radius_reg) * (SW-2)'(inner_radius_reg);
            s2_ro2_reg   <= (SW-2)'(outer_radius_reg) * (SW-2)'(outer_radius_reg);
            s2_sign_reg  <= s1_sign_reg;
            s2_degen_reg <= s1_degen_reg;
        end
    end

    // Stage 3: squared distance.
    logic [SW-1:0] s3_sum_reg;
    logic [SW-3:0] s3_ri2_reg, s3_ro2_reg;
    logic [RW-1:0] s3_mag_reg [3];
    logic [2:0]    s3_sign_reg;
    logic          s3_degen_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            s3_sum_reg   <= s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
            s3_ri2_reg   <= s2_ri2_reg;
            s3_ro2_reg   <= s2_ro2_reg;
            s3_mag_reg   <= s2_mag_reg;
            s3_sign_reg  <= s2_sign_reg;
            s3_degen_reg <= s2_degen_reg;
        end
    end

    // Square root pipeline; entry 0 is the region stage, entry k+1 holds the
    // partial root after root bit RW-1-k has been decided.
    logic [SW-1:0] sq_rem_reg    [RW+1];
    logic [RW-1:0] sq_root_reg   [RW+1];
    logic [RW-1:0] sq_mag_reg    [RW+1][3];
    logic [2:0]    sq_sign_reg   [RW+1];
    logic          sq_degen_reg  [RW+1];
    logic [1:0]    sq_region_reg [RW+1];

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            if (s3_sum_reg >= SW'(s3_ro2_reg))
            begin
                sq_region_reg[0] <= ssre_pkg::REGION_OUTER;
            end
            else if (s3_sum_reg < SW'(s3_ri2_reg))
            begin
                sq_region_reg[0] <= ssre_pkg::REGION_INNER;
            end
            else
            begin
                sq_region_reg[0] <= ssre_pkg::REGION_BLEND;
            end
            sq_rem_reg[0]   <= s3_sum_reg;
            sq_root_reg[0]  <= '0;
            sq_mag_reg[0]   <= s3_mag_reg;
            sq_sign_reg[0]  <= s3_sign_reg;
            sq_degen_reg[0] <= s3_degen_reg;
        end
    end

    generate
        for (gi = 0; gi < RW; gi++)
        begin : g_sqrt
            localparam int BIT = RW - 1 - gi;
            logic [SW-1:0] trial;
            logic          take;
            // (root + 2^BIT)^2 - root^2, with the low root bits still zero
            assign trial = (SW'(sq_root_reg[gi]) << (BIT + 1)) | (SW'(1) << (2 * BIT));
            assign take  = sq_rem_reg[gi] >= trial;

            always_ff @(posedge clk)
            begin
                if (stage_en[4+gi])
                begin
                    sq_rem_reg[gi+1]    <= take ? (sq_rem_reg[gi] - trial) : sq_rem_reg[gi];
                    sq_root_reg[gi+1]   <= sq_root_reg[gi] | (RW'(take) << BIT);
                    sq_mag_reg[gi+1]    <= sq_mag_reg[gi];
                    sq_sign_reg[gi+1]   <= sq_sign_reg[gi];
                    sq_degen_reg[gi+1]  <= sq_degen_reg[gi];
                    sq_region_reg[gi+1] <= sq_region_reg[gi];
                end
            end
        end
    endgenerate

    // Three restoring dividers, one quotient bit per stage. The offset never
    // exceeds the truncated root, so the partial remainder stays below twice
    // the divisor.
    logic [RW:0]   dv_rem_reg    [GQ][3];
    logic [GQ-1:0] dv_q_reg      [GQ][3];
    logic [RW-1:0] dv_dist_reg   [GQ];
    logic [2:0]    dv_sign_reg   [GQ];
    logic          dv_degen_reg  [GQ];
    logic [1:0]    dv_region_reg [GQ];

    generate
        for (gi = 0; gi < GQ; gi++)
        begin : g_div
            localparam int BIT = GQ - 1 - gi;
            logic [RW:0]   rem_in  [3];
            logic [GQ-1:0] q_in    [3];
            logic [RW-1:0] dist_in;
            logic [2:0]    sign_in;
            logic          degen_in;
            logic [1:0]    region_in;

            if (gi == 0)
            begin : g_first
                always_comb
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        rem_in[l] = {1'b0, sq_mag_reg[RW][l]};
                        q_in[l]   = '0;
                    end
                end
                assign dist_in   = sq_root_reg[RW];
                assign sign_in   = sq_sign_reg[RW];
                assign degen_in  = sq_degen_reg[RW];
                assign region_in = sq_region_reg[RW];
            end
            else
            begin : g_next
                assign rem_in    = dv_rem_reg[gi-1];
                assign q_in      = dv_q_reg[gi-1];
                assign dist_in   = dv_dist_reg[gi-1];
                assign sign_in   = dv_sign_reg[gi-1];
                assign degen_in  = dv_degen_reg[gi-1];
                assign region_in = dv_region_reg[gi-1];
            end

            always_ff @(posedge clk)
            begin
                if (stage_en[4+RW+gi])
                begin
                    for (int l = 0; l < 3; l++)
                    begin
                        if (rem_in[l] >= {1'b0, dist_in})
                        begin
                            dv_rem_reg[gi][l] <= (rem_in[l] - {1'b0, dist_in}) << 1;
                            dv_q_reg[gi][l]   <= q_in[l] | (GQ'(1) << BIT);
                        end
                        else
                        begin
                            dv_rem_reg[gi][l] <= rem_in[l] << 1;
                            dv_q_reg[gi][l]   <= q_in[l];
                        end
                    end
                    dv_dist_reg[gi]   <= dist_in;
                    dv_sign_reg[gi]   <= sign_in;
                    dv_degen_reg[gi]  <= degen_in;
                    dv_region_reg[gi] <= region_in;
                end
            end
        end
    endgenerate

    // Output stage: clamp, apply the sign and zero a degenerate gradient.
    localparam logic [GQ-1:0] GRAD_ONE = GQ'(1) << ssre_pkg::GRAD_FRAC;
    localparam logic signed [GW-1:0] GRAD_MAX_S = GW'(GRAD_ONE);

    logic [CW+1:0] out_dist_reg;
    logic [GW-1:0] out_grad_reg [3];
    logic [1:0]    out_region_reg;
    logic          out_degen_reg;
    logic [GW-1:0] grad_next [3];

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            grad_next[l] = (dv_q_reg[GQ-1][l] > GRAD_ONE) ? GW'(GRAD_ONE)
                                                          : GW'(dv_q_reg[GQ-1][l]);
            if (dv_degen_reg[GQ-1])
            begin
                grad_next[l] = '0;
            end
            else if (dv_sign_reg[GQ-1][l])
            begin
                grad_next[l] = GW'(0) - grad_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[NS-1])
        begin
            out_dist_reg   <= (CW+2)'(dv_dist_reg[GQ-1]);
            out_grad_reg   <= grad_next;
            out_region_reg <= dv_region_reg[GQ-1];
            out_degen_reg  <= dv_degen_reg[GQ-1];
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = OUT_W'({out_grad_reg[2], out_grad_reg[1], out_grad_reg[0], out_dist_reg});
    assign m_tuser  = {out_degen_reg, out_region_reg};

    logic                 out_grad_zero;
    logic signed [GW-1:0] out_grad_x_s;
    assign out_grad_zero = (out_grad_reg[0] == '0) && (out_grad_reg[1] == '0)
                           && (out_grad_reg[2] == '0);
    assign out_grad_x_s  = out_grad_reg[0];

    // A degenerate result has zero distance and zero gradient.
    `SSRE_ASSERT(a_degen_zero, clk, rst_n, m_tvalid && out_degen_reg |-> out_dist_reg == '0 && out_grad_zero)
    // Any other point lies at least one unit away.
    `SSRE_ASSERT(a_dist_nonzero, clk, rst_n, m_tvalid && !out_degen_reg |-> out_dist_reg != '0)
    // The x gradient never exceeds one in magnitude.
    `SSRE_ASSERT(a_grad_range, clk, rst_n, m_tvalid |-> out_grad_x_s <= GRAD_MAX_S && out_grad_x_s >= -GRAD_MAX_S)
    // When reset is seen low, no result is offered in the next cycle.
    `SSRE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !m_tvalid)

endmodule

`default_nettype wire

FILE: tb/spherical_shell_region_eval_tb.sv
// ----------------------------------------------------------------------------
// spherical_shell_region_eval_tb
// Streams query points through the shell evaluator under random back-pressure,
// predicts distance, gradient and region per point and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spherical_shell_region_eval_tb;

    localparam int CW    = 32;
    localparam int IN_W  = 96;
    localparam int OUT_W = 136;
    localparam int LAT   = CW + 37;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [1:0]  region;
        logic        degenerate;
        logic [33:0] distance;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] gz;
    } shell_result_t;

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [OUT_W-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_we = 0;
    logic [ssre_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_wdata = '0;

    int errors = 0;
    int idle_cycles = 0;
    int points_sent = 0;
    int results_seen = 0;
    int cfg_sets = 0;
    bit stim_done = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    spherical_shell_region_eval #(.COORD_WIDTH(CW)) dut (.*);

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got %h expected %h", what, got, want);
    endtask

    class shell_scoreboard;
        logic signed [CW-1:0] cx, cy, cz;
        logic [CW-2:0] r_in, r_out;
        shell_result_t pending[$];

        function void set_reg(logic [ssre_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] v);
            case (idx)
                ssre_pkg::CFG_CENTER_X:     cx = v;
                ssre_pkg::CFG_CENTER_Y:     cy = v;
                ssre_pkg::CFG_CENTER_Z:     cz = v;
                ssre_pkg::CFG_INNER_RADIUS: r_in = v[CW-2:0];
                ssre_pkg::CFG_OUTER_RADIUS: r_out = v[CW-2:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] grad(logic signed [33:0] off, logic [33:0] dvsr);
            logic [33:0] mag;
            logic [95:0] q;
            mag = off[33] ? -off : off;
            q = ({62'd0, mag} << ssre_pkg::GRAD_FRAC) / dvsr;
            if (q > (96'd1 << ssre_pkg::GRAD_FRAC)) q = 96'd1 << ssre_pkg::GRAD_FRAC;
            if (off[33]) q = -q;
            return q[31:0];
        endfunction

        function void note_point(logic [IN_W-1:0] d);
            logic signed [33:0] dx, dy, dz;
            logic [33:0] ax, ay, az;
            logic [69:0] s;
            logic [71:0] cand_sq;
            logic [35:0] root, cand;
            shell_result_t r;
            dx = $signed(d[31:0]) - cx;
            dy = $signed(d[63:32]) - cy;
            dz = $signed(d[95:64]) - cz;
            ax = dx[33] ? -dx : dx;
            ay = dy[33] ? -dy : dy;
            az = dz[33] ? -dz : dz;
            s = 70'(ax) * ax + 70'(ay) * ay + 70'(az) * az;
            root = 0;
            for (int b = 35; b >= 0; b--)
            begin
                cand = root | (36'd1 << b);
                cand_sq = 72'(cand) * cand;
                if (s >= cand_sq) root = cand;
            end
            r.distance = (root > 36'h3_FFFF_FFFF) ? 34'h3_FFFF_FFFF : root[33:0];
            if (s >= 70'(r_out) * r_out) r.region = ssre_pkg::REGION_OUTER;
            else if (s < 70'(r_in) * r_in) r.region = ssre_pkg::REGION_INNER;
            else r.region = ssre_pkg::REGION_BLEND;
            if (s == 0)
            begin
                r.degenerate = 1;
                r.gx = 0; r.gy = 0; r.gz = 0;
            end
            else
            begin
                r.degenerate = 0;
                r.gx = grad(dx, r.distance);
                r.gy = grad(dy, r.distance);
                r.gz = grad(dz, r.distance);
            end
            pending.push_back(r);
        endfunction

        task check_result(logic [OUT_W-1:0] d, logic [2:0] u);
            shell_result_t e;
            if (pending.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(d[33:0]), 0);
                return;
            end
            e = pending.pop_front();
            if (d[33:0] !== e.distance) report_mismatch("distance", d[33:0], e.distance);
            if (d[65:34] !== e.gx) report_mismatch("grad_x", d[65:34], e.gx);
            if (d[97:66] !== e.gy) report_mismatch("grad_y", d[97:66], e.gy);
            if (d[129:98] !== e.gz) report_mismatch("grad_z", d[129:98], e.gz);
            if (u[1:0] !== e.region) report_mismatch("region", u[1:0], e.region);
            if (u[2] !== e.degenerate) report_mismatch("degenerate", u[2], e.degenerate);
        endtask
    endclass

    shell_scoreboard sb = new();

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(input logic [ssre_pkg::CFG_IDX_W-1:0] idx,
                             input logic [CW-1:0] v);
        @(posedge clk);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        int g;
        g = gap_len();
        // With no gap, valid stays high and the next item follows at once.
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_point({z, y, x});
        points_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LAT + 5) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [30:0] ri,
                             input logic [30:0] ro);
        write_reg(ssre_pkg::CFG_CENTER_X, x);
        write_reg(ssre_pkg::CFG_CENTER_Y, y);
        write_reg(ssre_pkg::CFG_CENTER_Z, z);
        write_reg(ssre_pkg::CFG_INNER_RADIUS, {1'b0, ri});
        write_reg(ssre_pkg::CFG_OUTER_RADIUS, {1'b0, ro});
        cfg_sets++;
    endtask

    task automatic random_phase(input int n, input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] cz, input logic [30:0] rmax);
        logic [31:0] x, y, z;
        int m;
        for (int i = 0; i < n; i++)
        begin
            m = $urandom_range(0, 9);
            if (m < 5)
            begin
                // Points near the center, so the shell boundaries get crossed.
                x = cx + 32'($signed($urandom_range(0, 2 * rmax / 2 + 2)) - rmax / 2);
                y = cy + 32'($signed($urandom_range(0, 2 * rmax / 2 + 2)) - rmax / 2);
                z = cz + 32'($signed($urandom_range(0, 2 * rmax / 2 + 2)) - rmax / 2);
                if (m == 0)
                begin
                    x = cx; y = cy; z = cz;
                end
            end
            else
            begin
                x = rand_coord($urandom_range(0, 4));
                y = rand_coord($urandom_range(0, 4));
                z = rand_coord($urandom_range(0, 4));
            end
            send_point(x, y, z);
        end
    endtask

    // Result side: random stalls.
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                m_tready <= 0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata, m_tuser);
            results_seen++;
        end
    end

    // Watchdog: cycles in which no item moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else if (!stim_done || sb.pending.size() != 0)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Watchdog expired");
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        sb.set_reg(ssre_pkg::CFG_CENTER_X, 0);
        sb.set_reg(ssre_pkg::CFG_CENTER_Y, 0);
        sb.set_reg(ssre_pkg::CFG_CENTER_Z, 0);
        sb.set_reg(ssre_pkg::CFG_INNER_RADIUS, 0);
        sb.set_reg(ssre_pkg::CFG_OUTER_RADIUS, 0);
        repeat (5) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Reset settings: zero radii, every point is outer.
        send_point(0, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 0, 0);
        send_point(0, 32'hFFFF_0000, 0);
        send_point(0, 0, 32'h0000_0001);
        drain();

        // Extreme center: offsets reach the full 33-bit span.
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(0, 0, 0);
        drain();

        // Small shell around a small center; exact radius and gradient rounding cases.
        configure(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0000, 31'd100, 31'd200);
        send_point(32'h0000_0100 + 100, 32'hFFFF_FF00, 0);
        send_point(32'h0000_0100 + 99, 32'hFFFF_FF00, 0);
        send_point(32'h0000_0100 + 200, 32'hFFFF_FF00, 0);
        send_point(32'h0000_0100 + 199, 32'hFFFF_FF00, 0);
        send_point(32'h0000_0101, 32'hFFFF_FF01, 32'h0000_0001);
        send_point(32'h0000_0100, 32'hFFFF_FF00, 0);
        drain();

        // Inner radius above outer radius: blend is empty.
        configure(0, 0, 0, 31'd500, 31'd300);
        send_point(100, 0, 0);
        send_point(400, 0, 0);
        send_point(600, 0, 0);
        drain();

        random_phase(300, 32'h0000_0100, 32'hFFFF_FF00, 0, 31'd400);
        drain();
        configure(32'h0000_0100, 32'hFFFF_FF00, 0, 31'd150, 31'd300);
        random_phase(300, 32'h0000_0100, 32'hFFFF_FF00, 0, 31'd400);
        drain();
        configure($urandom(), $urandom(), $urandom(), 31'h0100_0000, 31'h4000_0000);
        random_phase(250, sb.cx, sb.cy, sb.cz, 31'h4000_0000);

        stim_done = 1;
        drain();
        $display("Covered %0d points and %0d results over %0d register settings.",
                 points_sent, results_seen, cfg_sets);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/ssre_pkg.sv
sv/spherical_shell_region_eval.sv
tb/spherical_shell_region_eval_tb.sv
